>>> rtl/core/owmst_pkg.sv
package owmst_pkg;

	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned TICK_W        = 10;
	localparam int unsigned BITPOS_W      = 3;
	localparam int unsigned REG_IDX_W     = 3;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RESET_LOW     = 3'd0,
		REG_PRESENCE_WAIT = 3'd1,
		REG_RESET_RECOVER = 3'd2,
		REG_SHORT_LOW     = 3'd3,
		REG_WRITE_ZERO    = 3'd4,
		REG_READ_SAMPLE   = 3'd5,
		REG_SLOT_LEN      = 3'd6
	} reg_idx_t;

	localparam logic [TICK_W-1:0] RST_RESET_LOW     = 10'd480;
	localparam logic [TICK_W-1:0] RST_PRESENCE_WAIT = 10'd70;
	localparam logic [TICK_W-1:0] RST_RESET_RECOVER = 10'd410;
	localparam logic [TICK_W-1:0] RST_SHORT_LOW     = 10'd6;
	localparam logic [TICK_W-1:0] RST_WRITE_ZERO    = 10'd60;
	localparam logic [TICK_W-1:0] RST_READ_SAMPLE   = 10'd9;
	localparam logic [TICK_W-1:0] RST_SLOT_LEN      = 10'd70;

	typedef struct packed {
		logic [TICK_W-1:0] reset_low_us;
		logic [TICK_W-1:0] presence_wait_us;
		logic [TICK_W-1:0] reset_recover_us;
		logic [TICK_W-1:0] short_low_us;
		logic [TICK_W-1:0] write_zero_low_us;
		logic [TICK_W-1:0] read_sample_us;
		logic [TICK_W-1:0] slot_len_us;
	} cfg_regs_t;

	typedef struct packed {
		logic       line_level;
		logic [7:0] data_byte;
		op_t        op;
	} cmd_t;

	typedef struct packed {
		logic       rejected;
		logic [7:0] read_data;
		logic       presence;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} res_t;

endpackage

>>> rtl/core/owmst_cfg.sv
module owmst_cfg
	import owmst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [TICK_W-1:0]    wr_data,
	output cfg_regs_t            regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.reset_low_us      <= RST_RESET_LOW;
			regs_q.presence_wait_us  <= RST_PRESENCE_WAIT;
			regs_q.reset_recover_us  <= RST_RESET_RECOVER;
			regs_q.short_low_us      <= RST_SHORT_LOW;
			regs_q.write_zero_low_us <= RST_WRITE_ZERO;
			regs_q.read_sample_us    <= RST_READ_SAMPLE;
			regs_q.slot_len_us       <= RST_SLOT_LEN;
		end else if (wr_en) begin
			case (wr_index)
				REG_RESET_LOW:     regs_q.reset_low_us      <= wr_data;
				REG_PRESENCE_WAIT: regs_q.presence_wait_us  <= wr_data;
				REG_RESET_RECOVER: regs_q.reset_recover_us  <= wr_data;
				REG_SHORT_LOW:     regs_q.short_low_us      <= wr_data;
				REG_WRITE_ZERO:    regs_q.write_zero_low_us <= wr_data;
				REG_READ_SAMPLE:   regs_q.read_sample_us    <= wr_data;
				REG_SLOT_LEN:      regs_q.slot_len_us       <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

>>> rtl/core/owmst_core.sv
module owmst_core
	import owmst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  cmd_t      cmd,
	input  cfg_regs_t cfg,
	output res_t      res
);

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_RST_LOW     = 3'd1,
		PH_RST_WAIT    = 3'd2,
		PH_RST_RECOVER = 3'd3,
		PH_SLOT        = 3'd4
	} phase_t;

	localparam logic [TICK_W-1:0]   TICK_MAX = '1;
	localparam logic [BITPOS_W:0]   LAST_BIT = (BITPOS_W+1)'(BITS_PER_BYTE);

	phase_t              phase_q, phase_n;
	op_t                 kind_q, kind_n;
	logic [TICK_W-1:0]   tick_q, tick_n;
	logic [BITPOS_W-1:0] bit_q, bit_n;
	logic [7:0]          shift_q, shift_n;
	logic                pres_q, pres_n;
	logic [7:0]          rdata_q, rdata_n;

	logic [TICK_W-1:0]   tick_inc;
	logic [TICK_W-1:0]   low_len;
	logic [TICK_W:0]     sample_at;
	logic                drive, done, rej;

	always_comb begin
		tick_inc  = (tick_q < TICK_MAX) ? tick_q + 1'b1 : tick_q;
		low_len   = (kind_q == OP_WRITE && !shift_q[bit_q]) ? cfg.write_zero_low_us
		                                                   : cfg.short_low_us;
		sample_at = {1'b0, low_len} + {1'b0, cfg.read_sample_us};

		phase_n = phase_q;
		kind_n  = kind_q;
		tick_n  = tick_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		pres_n  = pres_q;
		rdata_n = rdata_q;
		drive   = 1'b0;
		done    = 1'b0;
		rej     = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (cmd.op != OP_TICK) begin
				kind_n = cmd.op;
				tick_n = '0;
				bit_n  = '0;
				drive  = 1'b1;
				if (cmd.op == OP_RESET) begin
					pres_n  = 1'b0;
					phase_n = PH_RST_LOW;
				end else begin
					shift_n = (cmd.op == OP_WRITE) ? cmd.data_byte : 8'h00;
					phase_n = PH_SLOT;
				end
			end
		end else begin
			rej    = (cmd.op != OP_TICK);
			tick_n = tick_inc;
			unique case (phase_q)
				PH_RST_LOW: begin
					drive = 1'b1;
					if (tick_inc >= cfg.reset_low_us) begin
						phase_n = PH_RST_WAIT;
						tick_n  = '0;
						drive   = 1'b0;
					end
				end
				PH_RST_WAIT: begin
					if (tick_inc >= cfg.presence_wait_us) begin
						pres_n  = !cmd.line_level;
						phase_n = PH_RST_RECOVER;
						tick_n  = '0;
					end
				end
				PH_RST_RECOVER: begin
					if (tick_inc >= cfg.reset_recover_us) begin
						phase_n = PH_IDLE;
						tick_n  = '0;
						done    = 1'b1;
					end
				end
				default: begin
					if (kind_q == OP_READ && {1'b0, tick_inc} == sample_at)
						shift_n[bit_q] = shift_q[bit_q] | cmd.line_level;
					if (tick_inc >= cfg.slot_len_us) begin
						tick_n = '0;
						if ({1'b0, bit_q} + 1'b1 >= LAST_BIT) begin
							if (kind_q == OP_READ)
								rdata_n = shift_n;
							phase_n = PH_IDLE;
							bit_n   = '0;
							done    = 1'b1;
						end else begin
							bit_n = bit_q + 1'b1;
							drive = 1'b1;
						end
					end else begin
						drive = (tick_inc < low_len);
					end
				end
			endcase
		end

		res.drive_low = drive;
		res.busy_res  = (phase_n != PH_IDLE);
		res.done_res  = done;
		res.presence  = pres_n;
		res.read_data = rdata_n;
		res.rejected  = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= OP_TICK;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			rdata_q <= '0;
		end else if (en) begin
			phase_q <= phase_n;
			kind_q  <= kind_n;
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			pres_q  <= pres_n;
			rdata_q <= rdata_n;
		end
	end

`ifndef SYNTHESIS
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.done_res |=> phase_q == PH_IDLE && tick_q == '0 && bit_q == '0)
		else $error("operation finished but sequencer not parked");
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.rejected |-> phase_q != PH_IDLE)
		else $error("request rejected while idle");
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.drive_low |-> res.busy_res)
		else $error("line driven low with no operation running");
	a_idle_bitpos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bit_q == '0)
		else $error("bit position left over after operation");
`endif

endmodule

>>> rtl/core/onewire_master_slot_timer.sv
// One-wire bus master driven by one request per microsecond tick. Each request carries a
// command in s_tuser (tick only, bus reset, write byte, read byte), the byte to write and the
// bus level sampled during that tick; each request yields exactly one result with the line
// drive for the next tick, busy, done, presence, the last read byte and a reject flag for a
// command given while busy. A request is taken every cycle while m_tready is held high: it
// passes an input register, the sequencer steps once, and the result sits in an output
// register, so throughput is one request per cycle. Slot, reset and sample timings are set in
// ticks through the configuration port, which is always ready; write it only while no
// operation is running.
module onewire_master_slot_timer
	import owmst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,  // data_byte[7:0], line_level[8], zero pad
	input  logic [1:0]           s_tuser,  // op[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,  // drive_low, busy_res, done_res, presence,
	                                       // read_data[11:4], rejected[12], zero pad
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	logic      vld_s1, vld_s2;
	cmd_t      cmd_s1;
	res_t      res_s2;
	res_t      res;
	cfg_regs_t cfg;
	logic      adv;

	assign cfg_ready = 1'b1;
	assign adv       = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready  = !vld_s1 || adv;

	owmst_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (cfg)
	);

	owmst_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cmd    (cmd_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tready)
				vld_s1 <= s_tvalid;
			if (adv)
				vld_s2 <= 1'b1;
			else if (m_tready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1.op         <= op_t'(s_tuser);
			cmd_s1.data_byte  <= s_tdata[7:0];
			cmd_s1.line_level <= s_tdata[8];
		end
		if (adv)
			res_s2 <= res;
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {3'b000, res_s2};

endmodule

>>> sim/onewire_master_slot_timer_tb.sv
`timescale 1ns / 100ps

module onewire_master_slot_timer_tb;
	import owmst_pkg::*;

	localparam int CYCLE_LIMIT    = 1000000;
	localparam int TRAFFIC_TARGET = 200;

	localparam cfg_regs_t TIMING_DEFAULT = '{RST_RESET_LOW, RST_PRESENCE_WAIT,
		RST_RESET_RECOVER, RST_SHORT_LOW, RST_WRITE_ZERO, RST_READ_SAMPLE, RST_SLOT_LEN};
	localparam cfg_regs_t TIMING_MIN  = '{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd2};
	localparam cfg_regs_t TIMING_PAST = '{10'd3, 10'd2, 10'd3, 10'd4, 10'd5, 10'd3, 10'd3};
	localparam cfg_regs_t TIMING_ZERO = '0;
	localparam cfg_regs_t TIMING_WIDE = '{10'd2, 10'd2, 10'd2, 10'd1023, 10'd1023,
		10'd1023, 10'd4};

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_RECOVER,
		PH_SLOT
	} bus_phase_t;

	typedef struct {
		bit         reload;
		cfg_regs_t  timing;
		op_t        op;
		logic [7:0] data;
		logic       level;
		int         reps;
		bit         fixed;
		res_t       want;
	} bus_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;
	logic [1:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	// bus master as the testbench sees it
	cfg_regs_t   bus_timing;
	bus_phase_t  bus_phase;
	op_t         bus_kind;
	int unsigned bus_ticks;
	logic [2:0]  bus_bit;
	logic [7:0]  bus_shift;
	logic        bus_presence;
	logic [7:0]  bus_rdata;

	res_t     bus_expect [$];
	bus_row_t bus_script [33];
	res_t     want_res;
	res_t     got_res;

	int src_idle_pct;
	int rcv_idle_pct;
	int cycle_count;
	int mismatches;
	int requests_sent;
	int results_seen;
	int traffic_items;
	int timing_loads;
	int refused;
	int starts [4];

	onewire_master_slot_timer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic res_t res_of(input logic drv, busy, done, pres,
			input logic [7:0] rd, input logic rej);
		res_t r;
		r.drive_low = drv;
		r.busy_res  = busy;
		r.done_res  = done;
		r.presence  = pres;
		r.read_data = rd;
		r.rejected  = rej;
		return r;
	endfunction

	function automatic res_t bus_step(input op_t op, input logic [7:0] data, input logic level);
		res_t        r;
		int unsigned low_ticks;
		r = '0;
		if (bus_phase == PH_IDLE) begin
			if (op != OP_TICK) begin
				starts[op]++;
				bus_kind    = op;
				bus_ticks   = 0;
				bus_bit     = '0;
				r.drive_low = 1'b1;
				if (op == OP_RESET) begin
					bus_presence = 1'b0;
					bus_phase    = PH_RST_LOW;
				end else begin
					bus_shift = (op == OP_WRITE) ? data : 8'h00;
					bus_phase = PH_SLOT;
				end
			end
		end else begin
			if (op != OP_TICK) begin
				r.rejected = 1'b1;
				refused++;
			end
			if (bus_ticks < 1023)
				bus_ticks++;
			case (bus_phase)
				PH_RST_LOW: begin
					r.drive_low = 1'b1;
					if (bus_ticks >= bus_timing.reset_low_us) begin
						bus_phase   = PH_RST_WAIT;
						bus_ticks   = 0;
						r.drive_low = 1'b0;
					end
				end
				PH_RST_WAIT: begin
					if (bus_ticks >= bus_timing.presence_wait_us) begin
						bus_presence = ~level;
						bus_phase    = PH_RST_RECOVER;
						bus_ticks    = 0;
					end
				end
				PH_RST_RECOVER: begin
					if (bus_ticks >= bus_timing.reset_recover_us) begin
						bus_phase  = PH_IDLE;
						bus_ticks  = 0;
						r.done_res = 1'b1;
					end
				end
				default: begin
					low_ticks = (bus_kind == OP_WRITE && !bus_shift[bus_bit]) ?
						bus_timing.write_zero_low_us : bus_timing.short_low_us;
					if (bus_kind == OP_READ && bus_ticks == low_ticks + bus_timing.read_sample_us)
						bus_shift[bus_bit] = bus_shift[bus_bit] | level;
					if (bus_ticks >= bus_timing.slot_len_us) begin
						bus_ticks = 0;
						if (bus_bit == BITS_PER_BYTE - 1) begin
							if (bus_kind == OP_READ)
								bus_rdata = bus_shift;
							bus_phase  = PH_IDLE;
							bus_bit    = '0;
							r.done_res = 1'b1;
						end else begin
							bus_bit++;
							r.drive_low = 1'b1;
						end
					end else begin
						r.drive_low = (bus_ticks < low_ticks);
					end
				end
			endcase
		end
		r.busy_res  = (bus_phase != PH_IDLE);
		r.presence  = bus_presence;
		r.read_data = bus_rdata;
		return r;
	endfunction

	function automatic cfg_regs_t random_timing();
		cfg_regs_t t;
		t.reset_low_us      = TICK_W'($urandom_range(1, 10));
		t.presence_wait_us  = TICK_W'($urandom_range(1, 10));
		t.reset_recover_us  = TICK_W'($urandom_range(1, 10));
		t.short_low_us      = TICK_W'($urandom_range(1, 10));
		t.write_zero_low_us = TICK_W'($urandom_range(1, 10));
		t.read_sample_us    = TICK_W'($urandom_range(1, 10));
		t.slot_len_us       = TICK_W'($urandom_range(2, 14));
		return t;
	endfunction

	task automatic send_request(input op_t op, input logic [7:0] data, input logic level,
			input bit fixed, input res_t want);
		res_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, level, data};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		predicted = bus_step(op, data, level);
		bus_expect.push_back(fixed ? want : predicted);
		requests_sent++;
	endtask

	// mostly whole commands followed by ticks, with the odd command thrown in while busy
	task automatic run_traffic(input int n_items);
		int  sent;
		op_t op;
		for (sent = 0; sent < n_items || bus_phase != PH_IDLE; sent++) begin
			if (bus_phase == PH_IDLE)
				op = ($urandom_range(99) < 80) ? op_t'($urandom_range(1, 3)) : OP_TICK;
			else
				op = ($urandom_range(99) < 6) ? op_t'($urandom_range(1, 3)) : OP_TICK;
			send_request(op, 8'($urandom), 1'($urandom), 1'b0, '0);
			traffic_items++;
		end
	endtask

	task automatic run_command(input op_t op);
		send_request(op, 8'($urandom), 1'($urandom), 1'b0, '0);
		run_traffic(0);
	endtask

	// hold the source until every outstanding request has its result
	task automatic settle_bus();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (bus_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_timing(input cfg_regs_t t);
		for (int i = 0; i < 7; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= t[(6 - i) * TICK_W +: TICK_W];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid  <= 1'b0;
		bus_timing = t;
		timing_loads++;
	endtask

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (bus_expect.size() == 0) begin
					mismatches++;
					$display("%0t: result %h expected none", $time, m_tdata);
				end else begin
					want_res = bus_expect.pop_front();
					got_res  = m_tdata[12:0];
					check_field("drive_low", want_res.drive_low, got_res.drive_low);
					check_field("busy_res", want_res.busy_res, got_res.busy_res);
					check_field("done_res", want_res.done_res, got_res.done_res);
					check_field("presence", want_res.presence, got_res.presence);
					check_field("read_data", want_res.read_data, got_res.read_data);
					check_field("rejected", want_res.rejected, got_res.rejected);
					check_field("pad", 0, m_tdata[15:13]);
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = OP_TICK;
		m_tready     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_RESET_LOW;
		cfg_data     = '0;
		cycle_count  = 0;
		mismatches   = 0;
		bus_timing   = TIMING_DEFAULT;
		bus_phase    = PH_IDLE;
		bus_kind     = OP_TICK;
		bus_ticks    = 0;
		bus_bit      = '0;
		bus_shift    = '0;
		bus_presence = 1'b0;
		bus_rdata    = '0;
		src_idle_pct = 23;
		rcv_idle_pct = 53;

		bus_script = '{
			'{0, '0, OP_TICK,  8'h00, 1'b1,   1, 1, res_of(0, 0, 0, 0, 8'h00, 0)},
			'{0, '0, OP_RESET, 8'h00, 1'b1,   1, 1, res_of(1, 1, 0, 0, 8'h00, 0)},
			'{0, '0, OP_TICK,  8'h00, 1'b1,  10, 0, '0},
			'{0, '0, OP_READ,  8'hFF, 1'b1,   1, 1, res_of(1, 1, 0, 0, 8'h00, 1)},
			'{0, '0, OP_TICK,  8'h00, 1'b1, 538, 0, '0},
			'{0, '0, OP_TICK,  8'h00, 1'b0,   1, 0, '0},
			'{0, '0, OP_TICK,  8'h00, 1'b1, 409, 0, '0},
			'{0, '0, OP_RESET, 8'h00, 1'b1,   1, 1, res_of(0, 0, 1, 1, 8'h00, 1)},
			'{1, TIMING_MIN, OP_TICK, 8'h00, 1'b0, 0, 0, '0},
			'{0, '0, OP_WRITE, 8'hFF, 1'b1,   1, 0, '0},
			'{0, '0, OP_TICK,  8'h00, 1'b1,  17, 0, '0},
			'{0, '0, OP_WRITE, 8'h00, 1'b0,   1, 0, '0},
			'{0, '0, OP_TICK,  8'hFF, 1'b0,  17, 0, '0},
			'{0, '0, OP_READ,  8'h00, 1'b1,   1, 0, '0},
			'{0, '0, OP_TICK,  8'h00, 1'b1,  17, 0, '0},
			'{0, '0, OP_READ,  8'h00, 1'b0,   1, 0, '0},
			'{0, '0, OP_TICK,  8'h00, 1'b0,  17, 0, '0},
			'{0, '0, OP_RESET, 8'h00, 1'b0,   1, 0, '0},
			'{0, '0, OP_TICK,  8'h00, 1'b0,   4, 0, '0},
			'{0, '0, OP_RESET, 8'h00, 1'b1,   1, 1, res_of(1, 1, 0, 0, 8'h00, 0)},
			'{0, '0, OP_TICK,  8'h00, 1'b1,   4, 0, '0},
			'{1, TIMING_PAST, OP_TICK, 8'h00, 1'b0, 0, 0, '0},
			'{0, '0, OP_WRITE, 8'h5A, 1'b1,   1, 0, '0},
			'{0, '0, OP_TICK,  8'h00, 1'b1,  30, 0, '0},
			'{0, '0, OP_READ,  8'h00, 1'b1,   1, 0, '0},
			'{0, '0, OP_TICK,  8'h00, 1'b1,  30, 0, '0},
			'{1, TIMING_ZERO, OP_TICK, 8'h00, 1'b0, 0, 0, '0},
			'{0, '0, OP_RESET, 8'h00, 1'b0,   1, 0, '0},
			'{0, '0, OP_TICK,  8'h00, 1'b0,   5, 0, '0},
			'{0, '0, OP_WRITE, 8'hA5, 1'b1,   1, 0, '0},
			'{0, '0, OP_TICK,  8'h00, 1'b1,  10, 0, '0},
			'{0, '0, OP_READ,  8'h00, 1'b1,   1, 0, '0},
			'{0, '0, OP_TICK,  8'h00, 1'b1,  10, 0, '0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (bus_script[r]) begin
			if (bus_script[r].reload) begin
				run_traffic(0);
				settle_bus();
				load_timing(bus_script[r].timing);
			end else begin
				repeat (bus_script[r].reps)
					send_request(bus_script[r].op, bus_script[r].data, bus_script[r].level,
						bus_script[r].fixed, bus_script[r].want);
			end
		end

		traffic_items = 0;
		while (traffic_items < TRAFFIC_TARGET) begin
			if (traffic_items >= 2 * TRAFFIC_TARGET / 3) begin
				src_idle_pct = 0;
				rcv_idle_pct = 0;
			end else if (traffic_items >= TRAFFIC_TARGET / 3) begin
				src_idle_pct = 53;
				rcv_idle_pct = 23;
			end
			settle_bus();
			load_timing(random_timing());
			run_traffic(20);
		end

		// lengths at the top of the range against a short slot
		settle_bus();
		load_timing(TIMING_WIDE);
		run_command(OP_RESET);
		run_command(OP_WRITE);
		run_command(OP_READ);
		settle_bus();

		$display("Sent %0d tick requests over %0d timing sets:", requests_sent, timing_loads);
		$display("%0d bus resets, %0d writes, %0d reads, %0d refused while busy.",
			starts[OP_RESET], starts[OP_WRITE], starts[OP_READ], refused);
		$display("%0d results compared, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/owmst_pkg.sv
rtl/core/owmst_cfg.sv
rtl/core/owmst_core.sv
rtl/core/onewire_master_slot_timer.sv
sim/onewire_master_slot_timer_tb.sv
